// ----- sv/tes_pkg.sv -----
// Shared types, constants and a helper function for the timed event schedule table.
`default_nettype none

package tes_pkg;

    localparam int OP_W     = 2;
    localparam int LIGHT_W  = 9;
    localparam int DAY_W    = 4;
    localparam int MIN_W    = 11;
    localparam int KIND_W   = 2;
    localparam int SDAY_W   = 3;
    localparam int CNT_W    = 3;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_MAX_LIGHT   = 256;

    localparam logic [OP_W-1:0] OP_SCHED  = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LIGHT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd2;

    localparam logic [DAY_W-1:0] DAY_MON     = 4'd0;
    localparam logic [DAY_W-1:0] DAY_SAT     = 4'd5;
    localparam logic [DAY_W-1:0] DAY_SUN     = 4'd6;
    localparam logic [DAY_W-1:0] DAY_EVERY   = 4'd7;
    localparam logic [DAY_W-1:0] DAY_WEEKDAY = 4'd8;
    localparam logic [DAY_W-1:0] DAY_WEEKEND = 4'd9;

    localparam logic [CNT_W-1:0] CNT_SINGLE  = 3'd1;
    localparam logic [CNT_W-1:0] CNT_EVERY   = 3'd7;
    localparam logic [CNT_W-1:0] CNT_WEEKDAY = 3'd5;
    localparam logic [CNT_W-1:0] CNT_WEEKEND = 3'd2;

    typedef struct packed {
        logic              action;
        logic [SDAY_W-1:0] day;
        logic [MIN_W-1:0]  minute;
        logic [LIGHT_W-1:0] light;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic [SDAY_W-1:0] first;
        logic [CNT_W-1:0]  count;
    } t_day_plan;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WRITE,
        ST_SCAN,
        ST_REPLY,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic judge;
        logic wr_step;
        logic scan;
        logic reply;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            reject;
        logic            wr_last;
        logic            scan_done;
    } t_status;

    function automatic t_day_plan decode_day(input logic [DAY_W-1:0] day);
        t_day_plan p;
        p = '{valid: 1'b0, first: '0, count: '0};
        case (day) inside
            [DAY_MON:DAY_SUN]: p = '{valid: 1'b1, first: day[SDAY_W-1:0], count: CNT_SINGLE};
            DAY_EVERY:   p = '{valid: 1'b1, first: DAY_MON[SDAY_W-1:0], count: CNT_EVERY};
            DAY_WEEKDAY: p = '{valid: 1'b1, first: DAY_MON[SDAY_W-1:0], count: CNT_WEEKDAY};
            DAY_WEEKEND: p = '{valid: 1'b1, first: DAY_SAT[SDAY_W-1:0], count: CNT_WEEKEND};
            default:     p = '{valid: 1'b0, first: '0, count: '0};
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- sv/timed_event_schedule_table.sv -----
// Top level of the timed event schedule table: controller plus datapath.
// Schedule: the result strobes after the 1, 2, 5 or 7 memory writes,
// or without any writes for a rejected or unknown transaction.
// Cancel and tick: unless a cancel is rejected, the memory is streamed one entry a cycle,
// and the final result strobes after the scan; tick light commands come out during the scan.
// A new start is taken in the cycle the final result strobes; results cannot be stalled.
// Synchronous active-low reset empties the table and idles the controller.
`default_nettype none

module timed_event_schedule_table
    import tes_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_LIGHT   = DEF_MAX_LIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [LIGHT_W-1:0] i_light_id,
    input  wire logic [DAY_W-1:0]   i_day,
    input  wire logic [MIN_W-1:0]   i_minute,
    input  wire logic               i_action,
    output logic                    o_strobe,
    output logic [KIND_W-1:0]       o_kind,
    output logic                    o_status,
    output logic [LIGHT_W-1:0]      o_cmd_light,
    output logic                    o_cmd_on,
    output logic                    o_last
);

    t_cmd    cmd;
    t_status status;

    tes_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    tes_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_LIGHT   (MAX_LIGHT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_op),
        .i_light_id   (i_light_id),
        .i_day        (i_day),
        .i_minute     (i_minute),
        .i_action     (i_action),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_status_bit (o_status),
        .o_cmd_light  (o_cmd_light),
        .o_cmd_on     (o_cmd_on),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ----- sv/tes_ctrl.sv -----
// Controller state machine that sequences schedule, cancel and tick transactions.
`default_nettype none

module tes_ctrl
    import tes_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (i_status.op)
                    OP_SCHED:  n_state = i_status.reject ? ST_REPLY : ST_WRITE;
                    OP_CANCEL: n_state = i_status.reject ? ST_REPLY : ST_SCAN;
                    OP_TICK:   n_state = ST_SCAN;
                    default:   n_state = ST_REPLY;
                endcase
            end
            ST_WRITE: begin
                if (i_status.wr_last) begin
                    n_state = ST_REPLY;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = (i_status.op == OP_TICK) ? ST_FLUSH : ST_REPLY;
                end
            end
            ST_REPLY: n_state = ST_IDLE;
            ST_FLUSH: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_DECIDE: o_cmd.judge   = 1'b1;
            ST_WRITE:  o_cmd.wr_step = 1'b1;
            ST_SCAN:   o_cmd.scan    = 1'b1;
            ST_REPLY:  o_cmd.reply   = 1'b1;
            ST_FLUSH:  o_cmd.flush   = 1'b1;
            default:   o_cmd         = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/tes_dp.sv -----
// Datapath with the event memory, entry count, scan pointers and result registers.
`default_nettype none

module tes_dp
    import tes_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int MAX_LIGHT   = DEF_MAX_LIGHT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [LIGHT_W-1:0] i_light_id,
    input  wire logic [DAY_W-1:0]   i_day,
    input  wire logic [MIN_W-1:0]   i_minute,
    input  wire logic               i_action,
    output logic                    o_strobe,
    output logic [KIND_W-1:0]       o_kind,
    output logic                    o_status_bit,
    output logic [LIGHT_W-1:0]      o_cmd_light,
    output logic                    o_cmd_on,
    output logic                    o_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);

    t_entry r_mem [TABLE_DEPTH];

    logic [OP_W-1:0]    r_op;
    logic [LIGHT_W-1:0] r_light;
    logic [DAY_W-1:0]   r_day;
    logic [MIN_W-1:0]   r_minute;
    logic               r_action;
    logic               r_reject;
    logic [CW-1:0]      r_total;
    logic [CNT_W-1:0]   r_wr_cnt;
    logic [CW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    t_entry             r_rd_data;
    logic [CW-1:0]      r_kept;
    logic               r_pend;
    logic [LIGHT_W-1:0] r_pend_light;
    logic               r_pend_on;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic               r_out_status;
    logic [LIGHT_W-1:0] r_out_light;
    logic               r_out_on;
    logic               r_out_last;

    logic               n_out_valid;
    logic [KIND_W-1:0]  n_out_kind;
    logic               n_out_status;
    logic [LIGHT_W-1:0] n_out_light;
    logic               n_out_on;
    logic               n_out_last;

    t_day_plan plan;
    logic      light_ok;
    logic      room_ok;
    logic      judge_reject;
    logic      rd_more;
    logic      tick_hit;
    logic      cancel_hit;
    t_entry    wr_entry;

    assign plan     = decode_day(r_day);
    assign light_ok = r_light <= LIGHT_W'(MAX_LIGHT);
    assign room_ok  = ({1'b0, r_total} + (CW + 1)'(plan.count)) <= (CW + 1)'(TABLE_DEPTH);
    assign rd_more  = r_rd_idx != r_total;

    assign tick_hit   = ({1'b0, r_rd_data.day} == r_day) && (r_rd_data.minute == r_minute);
    assign cancel_hit = tick_hit && (r_rd_data.light == r_light);

    always_comb begin
        case (r_op)
            OP_SCHED:  judge_reject = !(light_ok && plan.valid && room_ok);
            OP_CANCEL: judge_reject = !light_ok;
            OP_TICK:   judge_reject = 1'b0;
            default:   judge_reject = 1'b1;
        endcase
    end

    always_comb begin
        wr_entry.action = r_action;
        wr_entry.day    = plan.first + r_wr_cnt;
        wr_entry.minute = r_minute;
        wr_entry.light  = r_light;
    end

    assign o_status.op        = r_op;
    assign o_status.reject    = judge_reject;
    assign o_status.wr_last   = (r_wr_cnt + CNT_W'(1)) == plan.count;
    assign o_status.scan_done = !rd_more && !r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_step) begin
            r_mem[r_total[AW-1:0]] <= wr_entry;
        end else if (i_cmd.scan && r_rd_vld && (r_op == OP_CANCEL) && !cancel_hit) begin
            r_mem[r_kept[AW-1:0]] <= r_rd_data;
        end
        if (i_cmd.scan && rd_more) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    always_comb begin
        n_out_valid  = 1'b0;
        n_out_kind   = KIND_STATUS;
        n_out_status = 1'b0;
        n_out_light  = '0;
        n_out_on     = 1'b0;
        n_out_last   = 1'b0;
        if (i_cmd.scan && r_rd_vld && (r_op == OP_TICK) && tick_hit && r_pend) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_LIGHT;
            n_out_light = r_pend_light;
            n_out_on    = r_pend_on;
        end
        if (i_cmd.reply) begin
            n_out_valid  = 1'b1;
            n_out_status = r_reject;
            n_out_last   = 1'b1;
        end
        if (i_cmd.flush) begin
            n_out_valid = 1'b1;
            n_out_last  = 1'b1;
            if (r_pend) begin
                n_out_kind  = KIND_LIGHT;
                n_out_light = r_pend_light;
                n_out_on    = r_pend_on;
            end else begin
                n_out_kind = KIND_NOMATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_rd_vld    <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cmd.load) begin
                r_rd_vld <= 1'b0;
                r_pend   <= 1'b0;
            end
            if (i_cmd.wr_step) begin
                r_total <= r_total + CW'(1);
            end
            if (i_cmd.scan) begin
                r_rd_vld <= rd_more;
                if (r_rd_vld && (r_op == OP_TICK) && tick_hit) begin
                    r_pend <= 1'b1;
                end
            end
            if (i_cmd.reply && (r_op == OP_CANCEL) && !r_reject) begin
                r_total <= r_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_light  <= i_light_id;
            r_day    <= i_day;
            r_minute <= i_minute;
            r_action <= i_action;
            r_wr_cnt <= '0;
            r_rd_idx <= '0;
            r_kept   <= '0;
        end
        if (i_cmd.judge) begin
            r_reject <= judge_reject;
        end
        if (i_cmd.wr_step) begin
            r_wr_cnt <= r_wr_cnt + CNT_W'(1);
        end
        if (i_cmd.scan) begin
            if (rd_more) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (r_rd_vld && (r_op == OP_CANCEL) && !cancel_hit) begin
                r_kept <= r_kept + CW'(1);
            end
            if (r_rd_vld && (r_op == OP_TICK) && tick_hit) begin
                r_pend_light <= r_rd_data.light;
                r_pend_on    <= r_rd_data.action;
            end
        end
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_light  <= n_out_light;
        r_out_on     <= n_out_on;
        r_out_last   <= n_out_last;
    end

    assign o_strobe     = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_status_bit = r_out_status;
    assign o_cmd_light  = r_out_light;
    assign o_cmd_on     = r_out_on;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

// ----- sv/tes_checker.sv -----
// Port-level assertions for the timed event schedule table and their bind.
`default_nettype none

module tes_checker
    import tes_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire logic [KIND_W-1:0]  o_kind,
    input wire logic               o_status,
    input wire logic               o_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("block not idle after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind != KIND_LIGHT) |-> o_last)
        else $error("status or no-match result not marked last");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy |-> o_last)
        else $error("non-final result while idle");

    a_light_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == KIND_LIGHT) |-> !o_status)
        else $error("light command carries a reject status");

endmodule

bind timed_event_schedule_table tes_checker u_tes_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_kind   (o_kind),
    .o_status (o_status),
    .o_last   (o_last)
);

`default_nettype wire
